// File: sv/u16u8_pkg.sv
// ----------------------------------------------------------------------------
// u16u8_pkg
// Shared constants and types for the UTF-16 to UTF-8 encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package u16u8_pkg;

   localparam int UnitWidth  = 31;
   localparam int ByteWidth  = 8;
   localparam int MaxBytes   = 7;
   localparam int CodeBytes  = 6;
   localparam int CountWidth = 3;

   localparam logic [UnitWidth-1:0] HighFirst = 31'h0000_D800;
   localparam logic [UnitWidth-1:0] HighLast  = 31'h0000_DBFF;
   localparam logic [UnitWidth-1:0] LowFirst  = 31'h0000_DC00;
   localparam logic [UnitWidth-1:0] LowLast   = 31'h0000_DFFF;

   localparam logic [20:0] PlaneBase = 21'h01_0000;

   localparam logic [ByteWidth-1:0] Question = 8'h3F;
   localparam logic [ByteWidth-1:0] ContMark = 8'h80;
   localparam logic [ByteWidth-1:0] Lead2    = 8'hC0;
   localparam logic [ByteWidth-1:0] Lead3    = 8'hE0;
   localparam logic [ByteWidth-1:0] Lead4    = 8'hF0;
   localparam logic [ByteWidth-1:0] Lead5    = 8'hF8;
   localparam logic [ByteWidth-1:0] Lead6    = 8'hFC;

   // Encoded form of one value: number of bytes and the bytes, first at 0.
   typedef struct packed {
      logic [CountWidth-1:0]               len;
      logic [CodeBytes-1:0][ByteWidth-1:0] bytes;
   } code_type;

endpackage : u16u8_pkg

`default_nettype wire

// File: sv/utf16_to_utf8_encoder.sv
// ----------------------------------------------------------------------------
// utf16_to_utf8_encoder
// Converts wide code units, with surrogate pairing, into legacy UTF-8 bytes.
// ----------------------------------------------------------------------------
// The first byte of a word is shown once the word has passed from the input
// register into the byte buffer.
// One output byte per cycle while rsp_stall is low; a word that yields N bytes
// holds the byte buffer until all N are taken, a word that yields nothing loads none.
// The input register takes a new word while the byte buffer drains.
// Reset is synchronous and clears the held surrogate and all valid flags.
`default_nettype none

module utf16_to_utf8_encoder (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_valid,
   output logic                                        req_stall,
   input  wire logic [u16u8_pkg::UnitWidth-1:0]        req_code_unit,
   input  wire logic                                   req_end_of_text,
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_stall,
   output logic [u16u8_pkg::ByteWidth-1:0]             rsp_out_byte,
   output logic                                        rsp_run_last
);

   // Input register.
   logic                                 a_valid_ff, a_valid_in;
   logic [u16u8_pkg::UnitWidth-1:0]      a_unit_ff;
   logic                                 a_eot_ff;

   // Held high surrogate.
   logic                                 pend_valid_ff, pend_valid_in;
   logic [9:0]                           pend_bits_ff, pend_bits_in;

   // Byte buffer that feeds the result channel.
   logic                                                   b_valid_ff, b_valid_in;
   logic [u16u8_pkg::MaxBytes-1:0][u16u8_pkg::ByteWidth-1:0] b_bytes_ff, b_bytes_in;
   logic [u16u8_pkg::CountWidth-1:0]                       b_count_ff, b_count_in;
   logic [u16u8_pkg::CountWidth-1:0]                       b_idx_ff, b_idx_in;

   logic                                 req_accept;
   logic                                 rsp_take;
   logic                                 b_done;
   logic                                 a_move;
   logic                                 unit_is_high;
   logic                                 unit_is_low;
   logic                                 prefix;
   logic [20:0]                          pair_cp;
   logic [u16u8_pkg::UnitWidth-1:0]      enc_value;
   u16u8_pkg::code_type                  code;
   logic [u16u8_pkg::CountWidth-1:0]     enc_count;
   logic [u16u8_pkg::MaxBytes-1:0][u16u8_pkg::ByteWidth-1:0] enc_bytes;

   function automatic u16u8_pkg::code_type put_code(
      input logic [u16u8_pkg::UnitWidth-1:0] v
   );
      u16u8_pkg::code_type                 r;
      logic [u16u8_pkg::CodeBytes-1:0][5:0] g;
      logic [u16u8_pkg::ByteWidth-1:0]     lead;
      logic [2:0]                          top;
      logic [2:0]                          sel;
      r = '0;
      for (int i = 0; i < 5; i++) begin
         g[i] = v[6*i +: 6];
      end
      g[5] = {5'b0, v[30]};
      if (v < 31'h80) begin
         r.len = 3'd1;
      end else if (v < 31'h800) begin
         r.len = 3'd2;
      end else if (v < 31'h1_0000) begin
         r.len = 3'd3;
      end else if (v < 31'h20_0000) begin
         r.len = 3'd4;
      end else if (v < 31'h400_0000) begin
         r.len = 3'd5;
      end else begin
         r.len = 3'd6;
      end
      case (r.len)
         3'd2:    lead = u16u8_pkg::Lead2;
         3'd3:    lead = u16u8_pkg::Lead3;
         3'd4:    lead = u16u8_pkg::Lead4;
         3'd5:    lead = u16u8_pkg::Lead5;
         3'd6:    lead = u16u8_pkg::Lead6;
         default: lead = '0;
      endcase
      top = r.len - 3'd1;
      if (r.len == 3'd1) begin
         r.bytes[0] = {1'b0, v[6:0]};
      end else begin
         r.bytes[0] = lead | {2'b0, g[top]};
      end
      // Continuation bytes carry the lower six-bit groups, most significant first.
      for (int k = 1; k < u16u8_pkg::CodeBytes; k++) begin
         sel = top - 3'(k);
         if (3'(k) < r.len) begin
            r.bytes[k] = u16u8_pkg::ContMark | {2'b0, g[sel]};
         end
      end
      return r;
   endfunction

   assign unit_is_high = a_unit_ff inside {[u16u8_pkg::HighFirst:u16u8_pkg::HighLast]};
   assign unit_is_low  = a_unit_ff inside {[u16u8_pkg::LowFirst:u16u8_pkg::LowLast]};
   assign pair_cp      = u16u8_pkg::PlaneBase + {1'b0, pend_bits_ff, a_unit_ff[9:0]};

   always_comb begin
      prefix        = 1'b0;
      enc_value     = a_unit_ff;
      pend_valid_in = pend_valid_ff;
      pend_bits_in  = pend_bits_ff;
      if (pend_valid_ff && unit_is_low) begin
         enc_value = {10'b0, pair_cp};
         code      = put_code(enc_value);
      end else begin
         prefix = pend_valid_ff;
         if (unit_is_high) begin
            code = '0;
            if (a_eot_ff) begin
               code.len      = 3'd1;
               code.bytes[0] = u16u8_pkg::Question;
            end
         end else begin
            code = put_code(enc_value);
         end
      end
      if (a_move) begin
         pend_valid_in = unit_is_high && !a_eot_ff && !(pend_valid_ff && unit_is_low);
         pend_bits_in  = pend_valid_in ? a_unit_ff[9:0] : 10'b0;
      end
   end

   always_comb begin
      enc_count = {2'b0, prefix} + code.len;
      enc_bytes = '0;
      if (prefix) begin
         enc_bytes[0] = u16u8_pkg::Question;
         for (int k = 1; k < u16u8_pkg::MaxBytes; k++) begin
            enc_bytes[k] = code.bytes[k-1];
         end
      end else begin
         for (int k = 0; k < u16u8_pkg::CodeBytes; k++) begin
            enc_bytes[k] = code.bytes[k];
         end
      end
   end

   assign rsp_valid    = b_valid_ff;
   assign rsp_out_byte = b_bytes_ff[b_idx_ff];
   assign rsp_run_last = (b_idx_ff == b_count_ff - 3'd1);
   assign rsp_take     = b_valid_ff && !rsp_stall;
   assign b_done       = rsp_take && rsp_run_last;
   assign a_move       = a_valid_ff && (!b_valid_ff || b_done);
   assign req_stall    = a_valid_ff && !a_move;
   assign req_accept   = req_valid && !req_stall;

   always_comb begin
      a_valid_in = a_valid_ff;
      if (req_accept) begin
         a_valid_in = 1'b1;
      end else if (a_move) begin
         a_valid_in = 1'b0;
      end
   end

   always_comb begin
      b_valid_in = b_valid_ff;
      b_bytes_in = b_bytes_ff;
      b_count_in = b_count_ff;
      b_idx_in   = b_idx_ff;
      if (a_move && enc_count != '0) begin
         b_valid_in = 1'b1;
         b_bytes_in = enc_bytes;
         b_count_in = enc_count;
         b_idx_in   = '0;
      end else if (b_done) begin
         b_valid_in = 1'b0;
      end else if (rsp_take) begin
         b_idx_in = b_idx_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff    <= 1'b0;
         pend_valid_ff <= 1'b0;
         pend_bits_ff  <= '0;
         b_valid_ff    <= 1'b0;
         b_count_ff    <= '0;
         b_idx_ff      <= '0;
      end else begin
         a_valid_ff    <= a_valid_in;
         pend_valid_ff <= pend_valid_in;
         pend_bits_ff  <= pend_bits_in;
         b_valid_ff    <= b_valid_in;
         b_count_ff    <= b_count_in;
         b_idx_ff      <= b_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         a_unit_ff <= req_code_unit;
         a_eot_ff  <= req_end_of_text;
      end
      b_bytes_ff <= b_bytes_in;
   end

   // The read position always lies inside a nonempty byte run.
   a_idx_in_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (b_count_ff != 3'd0 && b_idx_ff < b_count_ff))
      else $error("byte index outside of the buffered run");

   // A completed surrogate pair never leaves a surrogate held.
   a_pair_clears: assert property (@(posedge clock) disable iff (reset)
      (a_move && pend_valid_ff && unit_is_low) |=> !pend_valid_ff)
      else $error("held surrogate survived a completed pair");

   // A word that yields bytes starts a fresh run at its first byte.
   a_run_load: assert property (@(posedge clock) disable iff (reset)
      (a_move && enc_count != 3'd0) |=> (rsp_valid && b_idx_ff == 3'd0))
      else $error("byte run not loaded from the input register");

   // Input is only held back while a word waits in the input register.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (a_valid_ff && b_valid_ff))
      else $error("input stalled without a waiting word");

endmodule : utf16_to_utf8_encoder

`default_nettype wire

// File: verif/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives wide code units into the UTF-16 to UTF-8 encoder and checks every
// output byte against a predicted byte stream. Surrogate pairing, broken
// pairs, the legacy 1- to 6-byte forms and random idling on both channels
// are covered.
// ----------------------------------------------------------------------------

class utf8_encoding_tracker;

   typedef struct {
      logic [u16u8_pkg::ByteWidth-1:0] value;
      logic                            last;
   } utf8_byte_type;

   utf8_byte_type                   expected_bytes[$];
   logic [u16u8_pkg::ByteWidth-1:0] word_bytes[$];
   bit                              held_valid;
   logic [9:0]                      held_bits;
   int unsigned                     failures;

   function void encode_value(logic [u16u8_pkg::UnitWidth-1:0] v);
      int                              cont;
      logic [u16u8_pkg::ByteWidth-1:0] lead;
      if (v < 31'h80) begin
         word_bytes.push_back(v[7:0]);
         return;
      end
      if (v < 31'h800) begin
         cont = 1;
         lead = u16u8_pkg::Lead2;
      end else if (v < 31'h1_0000) begin
         cont = 2;
         lead = u16u8_pkg::Lead3;
      end else if (v < 31'h20_0000) begin
         cont = 3;
         lead = u16u8_pkg::Lead4;
      end else if (v < 31'h400_0000) begin
         cont = 4;
         lead = u16u8_pkg::Lead5;
      end else begin
         cont = 5;
         lead = u16u8_pkg::Lead6;
      end
      word_bytes.push_back(lead | 8'(v >> (6 * cont)));
      for (int i = cont - 1; i >= 0; i--)
         word_bytes.push_back(u16u8_pkg::ContMark | 8'((v >> (6 * i)) & 31'h3F));
   endfunction

   // Works out the bytes that one accepted word causes.
   function void take_unit(logic [u16u8_pkg::UnitWidth-1:0] unit, logic end_of_text);
      utf8_byte_type entry;
      bit            paired;
      paired = 0;
      word_bytes.delete();
      if (held_valid) begin
         held_valid = 0;
         if (unit >= u16u8_pkg::LowFirst && unit <= u16u8_pkg::LowLast) begin
            encode_value(31'(u16u8_pkg::PlaneBase) + 31'({held_bits, unit[9:0]}));
            paired = 1;
         end else begin
            word_bytes.push_back(u16u8_pkg::Question);
         end
         held_bits = '0;
      end
      if (!paired) begin
         if (unit >= u16u8_pkg::HighFirst && unit <= u16u8_pkg::HighLast) begin
            if (end_of_text) begin
               word_bytes.push_back(u16u8_pkg::Question);
            end else begin
               held_valid = 1;
               held_bits  = unit[9:0];
            end
         end else begin
            encode_value(unit);
         end
      end
      foreach (word_bytes[i]) begin
         entry.value = word_bytes[i];
         entry.last  = (i == word_bytes.size() - 1);
         expected_bytes.push_back(entry);
      end
   endfunction

   function void match_byte(logic [u16u8_pkg::ByteWidth-1:0] value, logic last);
      utf8_byte_type entry;
      if (expected_bytes.size() == 0) begin
         $error("out_byte: no byte expected, actual %02h", value);
         failures++;
         return;
      end
      entry = expected_bytes.pop_front();
      if (value !== entry.value) begin
         $error("out_byte: expected %02h, actual %02h", entry.value, value);
         failures++;
      end
      if (last !== entry.last) begin
         $error("run_last: expected %0b, actual %0b", entry.last, last);
         failures++;
      end
   endfunction

endclass

module testbench;

   logic                            clock           = 1'b0;
   logic                            reset           = 1'b1;
   logic                            req_valid       = 1'b0;
   logic                            req_stall;
   logic [u16u8_pkg::UnitWidth-1:0] req_code_unit   = '0;
   logic                            req_end_of_text = 1'b0;
   logic                            rsp_valid;
   logic                            rsp_stall       = 1'b0;
   logic [u16u8_pkg::ByteWidth-1:0] rsp_out_byte;
   logic                            rsp_run_last;

   utf8_encoding_tracker tracker;
   bit                   sender_idle;
   bit                   receiver_idle;
   bit                   long_hold;
   int                   words_sent;

   utf16_to_utf8_encoder dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_code_unit   (req_code_unit),
      .req_end_of_text (req_end_of_text),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_run_last    (rsp_run_last)
   );

   always #5 clock = ~clock;

   initial begin
      #2_000_000;
      $display("Test completed with failures");
      $finish;
   end

   // Called just after a rising edge; returns just after the edge that took
   // the word.
   task automatic send_word(input logic [u16u8_pkg::UnitWidth-1:0] unit,
                            input logic end_of_text);
      if (sender_idle && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_code_unit   <= unit;
      req_end_of_text <= end_of_text;
      do @(posedge clock); while (req_stall);
      tracker.take_unit(unit, end_of_text);
      words_sent++;
   endtask

   task automatic send_random_word();
      int                              pick;
      logic                            end_of_text;
      logic [u16u8_pkg::UnitWidth-1:0] unit;
      pick        = int'($urandom_range(0, 99));
      end_of_text = ($urandom_range(0, 9) == 0);
      if (pick < 30) begin
         unit = 31'($urandom_range(0, 'h7F));
      end else if (pick < 45) begin
         unit = 31'($urandom_range('h80, 'h7FF));
      end else if (pick < 58) begin
         unit = $urandom_range(0, 1) ? 31'($urandom_range('h800, 'hD7FF))
                                     : 31'($urandom_range('hE000, 'hFFFF));
      end else if (pick < 75) begin
         // Well-formed pair with random content.
         send_word(31'($urandom_range(u16u8_pkg::HighFirst, u16u8_pkg::HighLast)), 1'b0);
         unit = 31'($urandom_range(u16u8_pkg::LowFirst, u16u8_pkg::LowLast));
      end else if (pick < 80) begin
         unit        = 31'($urandom_range(u16u8_pkg::HighFirst, u16u8_pkg::HighLast));
         end_of_text = ($urandom_range(0, 2) == 0);
      end else if (pick < 85) begin
         unit = 31'($urandom_range(u16u8_pkg::LowFirst, u16u8_pkg::LowLast));
      end else if (pick < 93) begin
         unit = 31'($urandom) >> $urandom_range(0, 15);
      end else begin
         unit = 31'($urandom);
      end
      send_word(unit, end_of_text);
   endtask

   // Receiver: checks bytes and drives the stall, including one long hold.
   initial begin
      int burst;
      int hold_left;
      burst     = 0;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall)
            tracker.match_byte(rsp_out_byte, rsp_run_last);
         if (long_hold) begin
            long_hold = 0;
            hold_left = 80;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (burst > 0) begin
            burst--;
            rsp_stall <= 1'b1;
         end else if (receiver_idle && $urandom_range(0, 5) == 0) begin
            burst = $urandom_range(1, 5) - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      tracker       = new;
      sender_idle   = 1;
      receiver_idle = 1;
      long_hold     = 0;
      words_sent    = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Boundaries of each encoded length.
      send_word(31'h0000_0000, 1'b0);
      send_word(31'h0000_007F, 1'b0);
      send_word(31'h0000_0080, 1'b0);
      send_word(31'h0000_07FF, 1'b0);
      send_word(31'h0000_0800, 1'b0);
      send_word(31'h0000_D7FF, 1'b0);
      send_word(31'h0000_E000, 1'b0);
      send_word(31'h0000_FFFF, 1'b0);
      send_word(31'h0001_0000, 1'b0);
      send_word(31'h001F_FFFF, 1'b0);
      send_word(31'h0020_0000, 1'b0);
      send_word(31'h03FF_FFFF, 1'b0);
      send_word(31'h0400_0000, 1'b0);
      send_word(31'h7FFF_FFFF, 1'b1);
      // Pairs at both ends; the pair ignores the end-of-text flag.
      send_word(31'h0000_D800, 1'b0);
      send_word(31'h0000_DC00, 1'b1);
      send_word(31'h0000_DBFF, 1'b0);
      send_word(31'h0000_DFFF, 1'b0);
      // A held high surrogate broken by a plain unit and by another high one.
      send_word(31'h0000_D800, 1'b0);
      send_word(31'h0000_0041, 1'b0);
      send_word(31'h0000_DA00, 1'b0);
      send_word(31'h0000_DB00, 1'b0);
      send_word(31'h0000_DC01, 1'b0);
      // High surrogate at the end of the text, then lone low surrogates.
      send_word(31'h0000_DBFF, 1'b1);
      send_word(31'h0000_DC00, 1'b0);
      send_word(31'h0000_DFFF, 1'b1);
      // Broken pair followed by a six-byte value gives seven bytes.
      send_word(31'h0000_D912, 1'b0);
      send_word(31'h7FFF_FFFF, 1'b0);

      // Receiver holds off while the sender keeps offering words.
      long_hold   = 1;
      sender_idle = 0;
      repeat (20) send_random_word();

      while (words_sent < 230) begin
         if (words_sent >= 190) begin
            sender_idle   = 0;
            receiver_idle = 0;
         end else begin
            sender_idle   = $urandom_range(0, 2) != 0;
            receiver_idle = $urandom_range(0, 2) != 0;
         end
         repeat (20) send_random_word();
      end
      req_valid <= 1'b0;

      while (tracker.expected_bytes.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (tracker.failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

// File: utf16_to_utf8_encoder.f
sv/u16u8_pkg.sv
sv/utf16_to_utf8_encoder.sv
verif/testbench.sv
